[sv/mbet_pkg.sv]
// Shared types and constants for the escape-time pixel core.
`timescale 1ns / 1ps
package mbet_pkg;
  localparam int FRAC_BITS = 28;
  localparam int QW = 32;
  localparam int SZW = 13;
  localparam int PIXW = 12;
  localparam logic [QW-1:0] RE_SPAN = 32'h3800_0000;   // 3.5
  localparam logic [QW-1:0] IM_SPAN = 32'h2000_0000;   // 2.0
  localparam logic signed [QW-1:0] RE_OFS = 32'shD800_0000; // -2.5
  localparam logic signed [QW-1:0] IM_OFS = 32'shF000_0000; // -1.0
  localparam logic signed [QW+3:0] FOUR_Q = 36'sh0_4000_0000;
  localparam int DIV_CELLS = 4;

  // Data passed from one divider cell to the next.
  typedef struct packed {
    logic [QW+1:0] rem;
    logic [QW-1:0] quo;
  } div_link_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAP  = 4'b0010,
    ST_ITER = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;
endpackage

[sv/mandelbrot_escape_time_pixel_core.sv]
// Top level of the escape-time pixel core: mapping, iteration and result.
// Mapping runs two divisions, each a load and 11 passes, then each iteration
// takes a product phase and a sum phase with its escape check. One pixel at
// a time: a new request is taken only after the last result strobe; busy stays
// high until the strobe. Reset (rst, synchronous) restores 1024 x 585, idles.
`timescale 1ns / 1ps
module mandelbrot_escape_time_pixel_core import mbet_pkg::*; #(
  parameter int MAX_ITERATIONS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [PIXW-1:0] row,
  input  logic [PIXW-1:0] col,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [0:0]      cfg_index,
  input  logic [SZW-1:0]  cfg_data,
  output logic            result_valid,
  output logic [10:0]     iteration_count,
  output logic            escaped,
  output logic [7:0]      intensity
);
  localparam int CW = $clog2(MAX_ITERATIONS + 1);
  localparam int AW = $clog2(MAX_ITERATIONS) + 1;
  localparam int Q_STEP = 255 / MAX_ITERATIONS;
  localparam int R_STEP = 255 % MAX_ITERATIONS;
  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  state_t state;
  logic [SZW-1:0] img_cols, img_rows;
  logic [PIXW-1:0] rowc, colc;
  logic [SZW-1:0] wm1, hm1;
  logic signed [QW-1:0] cre, cim, x, y, nx, ny;
  logic [CW-1:0] itr;
  logic phase, esc, second;
  logic div_go, div_done;
  logic [QW+PIXW-1:0] dividend;
  logic [SZW-1:0] divisor;
  logic [QW-1:0] quotient;
  logic [AW-1:0] frac_acc;
  logic [AW:0] acc_sum;
  logic [7:0] shade;

  // Hold config off in the cycle a request is taken.
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign busy = (state != ST_IDLE);

  // Divisors: size-1, with sizes below two giving a divisor of one.
  assign wm1 = (img_cols < SZW'(2)) ? SZW'(1) : (img_cols - 1'b1);
  assign hm1 = (img_rows < SZW'(2)) ? SZW'(1) : (img_rows - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      img_cols <= SZW'(1024);
      img_rows <= SZW'(585);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  img_cols <= cfg_data;
        REG_HEIGHT: img_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // First division maps the column, the second the flipped row.
  always_comb begin
    if (!second) begin
      dividend = QW'(colc) * RE_SPAN;
    end else begin
      dividend = QW'(hm1 - SZW'(rowc)) * IM_SPAN;
    end
    divisor = second ? hm1 : wm1;
  end

  mbet_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(dividend), .divisor(divisor),
    .done(div_done), .quotient(quotient)
  );

  mbet_iter u_iter (
    .clk(clk), .phase(phase), .x(x), .y(y), .cre(cre), .cim(cim),
    .esc(esc), .nx(nx), .ny(ny)
  );

  // Track count*255/MAX_ITERATIONS as the count advances: add the constant
  // quotient and remainder of 255/MAX_ITERATIONS, carry once the remainder reaches the cap.
  assign acc_sum = (AW+1)'(frac_acc) + (AW+1)'(R_STEP);

  // Launch a division on an accepted request and after the column quotient.
  always_ff @(posedge clk) begin
    div_go <= !rst && (((state == ST_IDLE) && start) ||
                       ((state == ST_MAP) && div_done && !second));
    result_valid <= !rst && (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
      second <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            // Clamp the pixel onto the image edge.
            colc <= (SZW'(col) > wm1) ? PIXW'(wm1) : col;
            rowc <= (SZW'(row) > hm1) ? PIXW'(hm1) : row;
            second <= 1'b0;
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (div_done) begin
            if (!second) begin
              cre <= $signed(quotient) + RE_OFS;
              second <= 1'b1;
            end else begin
              cim <= $signed(quotient) + IM_OFS;
              x <= '0;
              y <= '0;
              itr <= '0;
              frac_acc <= '0;
              shade <= '0;
              phase <= 1'b0;
              state <= ST_ITER;
            end
          end
        end
        ST_ITER: begin
          phase <= ~phase;
          if (phase) begin
            if (esc || itr == CW'(MAX_ITERATIONS)) begin
              state <= ST_DONE;
            end else begin
              x <= nx;
              y <= ny;
              itr <= itr + 1'b1;
              if (acc_sum >= (AW+1)'(MAX_ITERATIONS)) begin
                frac_acc <= AW'(acc_sum - (AW+1)'(MAX_ITERATIONS));
                shade <= shade + 8'(Q_STEP) + 8'd1;
              end else begin
                frac_acc <= AW'(acc_sum);
                shade <= shade + 8'(Q_STEP);
              end
            end
          end
        end
        ST_DONE: begin
          // Present the request result for one cycle.
          iteration_count <= 11'(itr);
          escaped <= (itr != CW'(MAX_ITERATIONS));
          intensity <= (itr != CW'(MAX_ITERATIONS)) ? shade : 8'd0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready) else $error("config taken while busy");
  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == ST_IDLE) else $error("result without idle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
endmodule

[sv/mbet_div_cell.sv]
// One restoring-division step cell: shifts in a dividend bit and subtracts.
`timescale 1ns / 1ps
module mbet_div_cell import mbet_pkg::*; (
  input  div_link_t       link_in,
  input  logic            bit_in,
  input  logic [SZW-1:0]  divisor,
  output div_link_t       link_out
);
  logic [QW+1:0] shifted;
  logic [QW+1:0] diff;
  always_comb begin
    shifted = {link_in.rem[QW:0], bit_in};
    diff = shifted - {{(QW+2-SZW){1'b0}}, divisor};
    if (!diff[QW+1]) begin
      link_out.rem = diff;
      link_out.quo = {link_in.quo[QW-2:0], 1'b1};
    end else begin
      link_out.rem = shifted;
      link_out.quo = {link_in.quo[QW-2:0], 1'b0};
    end
  end
endmodule

[sv/mbet_divider.sv]
// Sequential divider: a chain of DIV_CELLS step cells, one pass per cycle.
`timescale 1ns / 1ps
module mbet_divider import mbet_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [QW+PIXW-1:0] dividend,
  input  logic [SZW-1:0]    divisor,
  output logic              done,
  output logic [QW-1:0]     quotient
);
  localparam int NW = QW + PIXW;
  localparam int PASSES = NW / DIV_CELLS;
  logic [NW-1:0] num;
  div_link_t acc;
  div_link_t chain [DIV_CELLS+1];
  logic [$clog2(PASSES+1)-1:0] cnt;
  logic running;

  assign chain[0] = acc;
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    mbet_div_cell u_cell (
      .link_in(chain[i]), .bit_in(num[NW-1-i]), .divisor(divisor),
      .link_out(chain[i+1])
    );
  end
  assign quotient = acc.quo;

  always_ff @(posedge clk) begin
    done <= !rst && !go && running && (cnt == ($bits(cnt))'(PASSES - 1));
    if (rst) begin
      running <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      running <= 1'b1;
      cnt <= '0;
      num <= dividend;
      acc <= '0;
    end else if (running) begin
      acc <= chain[DIV_CELLS];
      num <= num << DIV_CELLS;
      cnt <= cnt + 1'b1;
      if (cnt == ($bits(cnt))'(PASSES - 1)) begin
        running <= 1'b0;
      end
    end
  end
endmodule

[sv/mbet_iter.sv]
// One z = z*z + c iteration in two phases: registered products, then sums.
`timescale 1ns / 1ps
module mbet_iter import mbet_pkg::*; (
  input  logic                 clk,
  input  logic                 phase,
  input  logic signed [QW-1:0] x,
  input  logic signed [QW-1:0] y,
  input  logic signed [QW-1:0] cre,
  input  logic signed [QW-1:0] cim,
  output logic                 esc,
  output logic signed [QW-1:0] nx,
  output logic signed [QW-1:0] ny
);
  logic signed [2*QW-1:0] pxx, pyy, pxy;
  logic signed [QW+3:0] xx, yy, xy2;
  always_ff @(posedge clk) begin
    if (!phase) begin
      pxx <= x * x;
      pyy <= y * y;
      pxy <= x * y;
    end
  end
  // Keep the squares wide: a point that just left the disk can square past 8.
  always_comb begin
    xx = pxx[2*QW-1:FRAC_BITS];
    yy = pyy[2*QW-1:FRAC_BITS];
    xy2 = pxy[2*QW-2:FRAC_BITS-1];
    esc = (xx + yy) >= FOUR_Q;
    nx = QW'(xx - yy + (QW+4)'(cre));
    ny = QW'(xy2 + (QW+4)'(cim));
  end
endmodule

[sim/tb_mandelbrot_escape_time_pixel_core.sv]
// Self-checking testbench for the escape-time pixel core.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_time_pixel_core;
  import mbet_pkg::*;

  localparam int MAX_ITERATIONS = 1024;
  localparam int FRAC = 28;
  // Register indexes of the configuration channel
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef struct {
    logic [PIXW-1:0] row;
    logic [PIXW-1:0] col;
  } pixel_t;

  typedef struct {
    logic [10:0] count;
    logic        esc;
    logic [7:0]  shade;
  } escape_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [PIXW-1:0] row;
  logic [PIXW-1:0] col;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [0:0]      cfg_index;
  logic [SZW-1:0]  cfg_data;
  logic            result_valid;
  logic [10:0]     iteration_count;
  logic            escaped;
  logic [7:0]      intensity;

  mandelbrot_escape_time_pixel_core #(.MAX_ITERATIONS(MAX_ITERATIONS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .row(row), .col(col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid),
    .iteration_count(iteration_count), .escaped(escaped), .intensity(intensity)
  );

  // Local copy of the size registers, tracked as writes complete
  logic [SZW-1:0] img_w;
  logic [SZW-1:0] img_h;

  pixel_t  pixel_q[$];     // requests not yet offered to the block
  escape_t escape_q[$];    // predicted results in acceptance order
  int      n_accepted;
  int      n_retired;
  int      n_errors;
  int      gap;
  bit      burst;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floor of a Q4.28 product: arithmetic shift rounds toward minus infinity
  function automatic longint qfloor(longint v);
    return v >>> FRAC;
  endfunction

  // Map the pixel into the plane and run the escape-time iteration
  function automatic escape_t escape_time(pixel_t p);
    longint unsigned wm1, hm1, r, c;
    longint          cre, cim, x, y, xx, yy, nx;
    int              n;
    escape_t         e;
    wm1 = (img_w < 2) ? 1 : img_w - 1;
    hm1 = (img_h < 2) ? 1 : img_h - 1;
    c = (p.col > wm1) ? wm1 : p.col;
    r = (p.row > hm1) ? hm1 : p.row;
    cre = longint'((c * (64'd7 << 27)) / wm1) - longint'(5) * (longint'(1) << 27);
    cim = longint'(((hm1 - r) * (64'd2 << FRAC)) / hm1) - (longint'(1) << FRAC);
    x = 0;
    y = 0;
    n = 0;
    while (n < MAX_ITERATIONS) begin
      xx = qfloor(x * x);
      yy = qfloor(y * y);
      if (xx + yy >= (longint'(4) << FRAC)) break;
      nx = xx - yy + cre;
      y = qfloor(2 * x * y) + cim;
      x = nx;
      n++;
    end
    e.count = n[10:0];
    e.esc = (n < MAX_ITERATIONS);
    e.shade = e.esc ? 8'((n * 255) / MAX_ITERATIONS) : 8'd0;
    return e;
  endfunction

  // Driver: present requests at the falling edge, hold start until taken
  int n_sent;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      row <= '0;
      col <= '0;
      n_sent = 0;
      gap = 0;
      burst = 1'b0;
    end else if (start && n_accepted != n_sent) begin
      // taken at the last rising edge: drop start and draw the next gap
      n_sent++;
      start <= 1'b0;
      if ($urandom_range(0, 15) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 4);
    end else if (!start) begin
      if (gap > 0) begin
        gap--;
      end else if (pixel_q.size() > 0) begin
        pixel_t p;
        p = pixel_q.pop_front();
        row <= p.row;
        col <= p.col;
        start <= 1'b1;
      end
    end
  end

  // Monitor: predict on acceptance, check each strobed result
  always @(posedge clk) begin
    if (rst) begin
      n_accepted <= 0;
    end else begin
      if (start && !busy) begin
        pixel_t p;
        p.row = row;
        p.col = col;
        escape_q.push_back(escape_time(p));
        n_accepted <= n_accepted + 1;
      end
      if (result_valid) begin
        if (escape_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: count=%0d esc=%0d shade=%0d",
                     iteration_count, escaped, intensity);
        end else begin
          escape_t e;
          e = escape_q.pop_front();
          if (iteration_count !== e.count || escaped !== e.esc ||
              intensity !== e.shade) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch #%0d: exp count=%0d esc=%0d shade=%0d, got %0d %0d %0d",
                       n_retired, e.count, e.esc, e.shade,
                       iteration_count, escaped, intensity);
          end
        end
        n_retired++;
      end
    end
  end

  // Wait until every request is taken and every result has come back
  task automatic drain();
    while (pixel_q.size() != 0 || start || escape_q.size() != 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [SZW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WIDTH) img_w = val;
    else img_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pixel(int r, int c);
    pixel_t p;
    p.row = r[PIXW-1:0];
    p.col = c[PIXW-1:0];
    pixel_q.push_back(p);
  endtask

  // Mostly pixels inside the image, some anywhere in the 12-bit range
  task automatic add_random(int cnt);
    int wl, hl;
    wl = (img_w < 2) ? 1 : ((img_w > 4096) ? 4095 : img_w - 1);
    hl = (img_h < 2) ? 1 : ((img_h > 4096) ? 4095 : img_h - 1);
    repeat (cnt) begin
      if ($urandom_range(0, 9) < 7)
        add_pixel($urandom_range(0, hl), $urandom_range(0, wl));
      else
        add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  int ws[7] = '{1024, 4096, 2, 0, 8191, 37, 1};
  int hs[7] = '{585, 4096, 2, 1, 3, 19, 8191};

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    img_w = 13'd1024;
    img_h = 13'd585;
    n_errors = 0;
    n_retired = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: corners, the origin (never escapes), edges and clamped pixels
    add_pixel(0, 0);
    add_pixel(584, 1023);
    add_pixel(0, 1023);
    add_pixel(584, 0);
    add_pixel(292, 731);       // c near zero: runs to the cap
    add_pixel(292, 0);         // far left on the real axis
    add_pixel(292, 1023);
    add_pixel(4095, 4095);     // beyond the image on both axes
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(2730, 1365);
    add_pixel(146, 585);
    add_pixel(300, 512);
    add_pixel(200, 800);
    drain();

    // Sweep the size registers, extremes and sub-minimum values included
    for (int k = 0; k < 7; k++) begin
      write_reg(REG_WIDTH, ws[k][SZW-1:0]);
      write_reg(REG_HEIGHT, hs[k][SZW-1:0]);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_random(78);
      drain();
    end

    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Run limit: far beyond every pixel running to the cap with maximal gaps
  initial begin
    #12000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
